[rtl/core/ipd_pkg.sv]
// Package for the instruction predecoder: constants, result type and opcode tables.
// Used by ipd_decode, the top level and the checker; depends on nothing.
package ipd_pkg;

	localparam logic [1:0] FMT_CTRL = 2'd0;
	localparam logic [1:0] FMT_COBR = 2'd1;
	localparam logic [1:0] FMT_REG  = 2'd2;
	localparam logic [1:0] FMT_MEM  = 2'd3;

	localparam logic [3:0] MODE_IP_REL   = 4'd5;
	localparam logic [3:0] MODE_RESERVED = 4'd6;

	typedef struct packed {
		logic        valid_res;
		logic [3:0]  length_bytes;
		logic [1:0]  format_class;
		logic [9:0]  opcode_index;
		logic [3:0]  operand_mask;
		logic [5:0]  operand_flags;
		logic [4:0]  field_a;
		logic [4:0]  field_b;
		logic [4:0]  field_c;
		logic [3:0]  mem_mode;
		logic [2:0]  scale_log2;
		logic [31:0] target_or_disp;
	} ipd_res_t;

	typedef struct packed {
		logic [31:0] instr_addr;
		logic [31:0] instr_word;
		logic [31:0] second_word;
	} ipd_in_t;

	// Table entries: bit 4 marks a defined opcode, bits 3..0 the operand mask.
	function automatic logic [4:0] ctrl_lookup(input logic [4:0] i);
		logic [4:0] r;
		r = 5'h00;
		case (i)
			5'h08, 5'h09, 5'h0b: r = 5'h11;
			5'h0a: r = 5'h10;
			5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h17: r = 5'h11;
			5'h18, 5'h19, 5'h1a, 5'h1b, 5'h1c, 5'h1d, 5'h1e, 5'h1f: r = 5'h10;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] cobr_lookup(input logic [4:0] i);
		logic [4:0] r;
		if (i[4]) r = 5'h13;
		else if (i[3]) r = 5'h00;
		else r = 5'h11;
		return r;
	endfunction

	function automatic logic [4:0] mem_lookup(input logic [6:0] i);
		logic [4:0] r;
		case (i)
			7'h00, 7'h05, 7'h08, 7'h0c, 7'h10, 7'h18, 7'h20, 7'h30, 7'h40, 7'h48:
				r = 5'h12;
			7'h02, 7'h0a, 7'h12, 7'h1a, 7'h22, 7'h32, 7'h42, 7'h4a: r = 5'h11;
			7'h04, 7'h06, 7'h2c: r = 5'h10;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

	// Per mode: bit3 long form, bit2 offset, bit1 base, bit0 index.
	function automatic logic [3:0] mode_lookup(input logic [3:0] m);
		logic [3:0] r;
		case (m)
			4'd0, 4'd1, 4'd2, 4'd3: r = 4'h4;
			4'd4: r = 4'h2;
			4'd5: r = 4'h8;
			4'd6: r = 4'h0;
			4'd7: r = 4'h3;
			4'd8, 4'd9, 4'd10, 4'd11: r = 4'h6;
			4'd12: r = 4'hC;
			4'd13: r = 4'hE;
			4'd14: r = 4'hD;
			default: r = 4'hF;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] reg_lookup(input logic [9:0] i);
		logic [4:0] r;
		case (i)
			10'h180, 10'h181, 10'h182, 10'h183, 10'h184, 10'h186, 10'h187, 10'h188,
			10'h189, 10'h18b, 10'h18c, 10'h18d, 10'h18e, 10'h18f, 10'h190, 10'h191,
			10'h192, 10'h193, 10'h198, 10'h19a, 10'h19b, 10'h19c, 10'h19d, 10'h19e,
			10'h1a4, 10'h1a5, 10'h1a6, 10'h1a7, 10'h1b0, 10'h1b2, 10'h1d8, 10'h203,
			10'h204, 10'h205, 10'h210, 10'h212, 10'h217, 10'h230, 10'h242, 10'h243,
			10'h245, 10'h250, 10'h251, 10'h254, 10'h255, 10'h259, 10'h25b, 10'h25c,
			10'h262, 10'h270, 10'h271, 10'h301, 10'h308, 10'h30b, 10'h341, 10'h348,
			10'h349, 10'h34b, 10'h380, 10'h381, 10'h382, 10'h383, 10'h384, 10'h390,
			10'h391, 10'h392, 10'h393, 10'h394, 10'h3a0, 10'h3a1, 10'h3a2, 10'h3a3,
			10'h3a4, 10'h3b0, 10'h3b1, 10'h3b2, 10'h3b3, 10'h3b4, 10'h3c0, 10'h3c1,
			10'h3c2, 10'h3c3, 10'h3c4, 10'h3d0, 10'h3d1, 10'h3d2, 10'h3d3, 10'h3d4,
			10'h3e0, 10'h3e1, 10'h3e2, 10'h3e3, 10'h3e4, 10'h3f0, 10'h3f1, 10'h3f2,
			10'h3f3, 10'h3f4: r = 5'h17;
			10'h18a, 10'h1ad, 10'h1cc, 10'h1dc, 10'h1ec, 10'h1fc, 10'h213, 10'h214,
			10'h215, 10'h240, 10'h241, 10'h244, 10'h246, 10'h256, 10'h258: r = 5'h15;
			10'h194, 10'h195, 10'h196, 10'h197, 10'h1a0, 10'h1a1, 10'h1a2, 10'h1a3,
			10'h1ac, 10'h1ae, 10'h200, 10'h201, 10'h202: r = 5'h13;
			10'h1b4, 10'h1b5, 10'h231, 10'h25d, 10'h266, 10'h26b, 10'h26c, 10'h26d,
			10'h26f: r = 5'h10;
			10'h260, 10'h263, 10'h264, 10'h265, 10'h268, 10'h269, 10'h26a: r = 5'h11;
			10'h273: r = 5'h14;
			10'h274, 10'h275, 10'h288, 10'h289, 10'h28a, 10'h28b, 10'h28c, 10'h28d,
			10'h28e, 10'h298, 10'h299, 10'h29a, 10'h29b, 10'h29c, 10'h29d, 10'h29e,
			10'h2c0, 10'h2c1, 10'h2c2, 10'h2c3, 10'h2c9, 10'h2d9, 10'h2e1: r = 5'h1d;
			10'h276, 10'h277, 10'h280, 10'h281, 10'h282, 10'h283, 10'h290, 10'h291,
			10'h292, 10'h293, 10'h2e2, 10'h2e3, 10'h38b, 10'h38c, 10'h38d, 10'h38f,
			10'h39b, 10'h39c, 10'h39d, 10'h39f: r = 5'h1f;
			10'h284, 10'h285, 10'h294, 10'h295: r = 5'h1b;
			10'h28f, 10'h29f: r = 5'h19;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/ipd_stream_if.sv]
// Valid/ready channel interface carrying a generic payload.
// The payload type is a parameter; the interface imports no package.
interface ipd_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ipd_decode.sv]
// Combinational decode of one instruction into a result record.
// Depends on ipd_pkg for the tables and the result type.
module ipd_decode
	import ipd_pkg::*;
(
	input  ipd_in_t  din,
	output ipd_res_t res
);
	logic [31:0] w;
	logic [31:0] a;
	logic [4:0]  ent;
	logic [3:0]  mf;
	logic [31:0] d;
	logic        ok;
	ipd_res_t    r;

	assign w = din.instr_word;
	assign a = din.instr_addr;

	always_comb begin
		r = '0;
		r.length_bytes = 4'd4;
		ent = '0;
		mf = '0;
		d = '0;
		ok = 1'b0;
		if (w[31]) begin
			r.format_class = FMT_MEM;
			r.opcode_index = {3'b000, w[30:24]};
			ent = mem_lookup(w[30:24]);
			r.mem_mode = w[13:10];
			mf = mode_lookup(w[13:10]);
			r.length_bytes = mf[3] ? 4'd8 : 4'd4;
			ok = ent[4] && (w[13:10] != MODE_RESERVED);
			r.scale_log2 = w[9:7];
			r.field_a = w[4:0];
			r.field_b = w[18:14];
			r.field_c = w[23:19];
			r.operand_flags = {2'b00, w[6], w[5], 2'b00};
			d = w[12] ? din.second_word : {20'd0, w[11:0]};
			if (w[13:10] == MODE_IP_REL) r.target_or_disp = a + 32'd8 + d;
			else if (mf[2]) r.target_or_disp = d;
		end else if (w[30]) begin
			r.format_class = FMT_REG;
			r.opcode_index = {w[29:24], w[10:7]};
			ent = reg_lookup({w[29:24], w[10:7]});
			ok = ent[4];
			r.field_a = w[4:0];
			r.field_b = w[18:14];
			r.field_c = w[23:19];
			r.operand_flags = {1'b0, w[13], w[6], w[5], w[12], w[11]};
		end else if (w[29]) begin
			r.format_class = FMT_COBR;
			r.opcode_index = {5'd0, w[28:24]};
			ent = cobr_lookup(w[28:24]);
			ok = ent[4];
			if (w[28]) begin
				r.field_a = w[23:19];
				r.field_b = w[18:14];
				r.operand_flags = {w[1], 1'b0, w[0], 2'b00, w[13]};
				r.target_or_disp = a + {{19{w[12]}}, w[12:2], 2'b00};
			end else begin
				r.field_c = w[23:19];
				r.operand_flags = {w[1], w[13], 4'b0000};
			end
		end else begin
			r.format_class = FMT_CTRL;
			r.opcode_index = {5'd0, w[28:24]};
			ent = ctrl_lookup(w[28:24]);
			ok = ent[4] && !w[0];
			r.operand_flags = {w[1], 5'b00000};
			if (ent[0]) r.target_or_disp = a + {{8{w[23]}}, w[23:2], 2'b00};
		end
		r.valid_res = ok;
		r.operand_mask = ent[3:0];
		if (!ok) begin
			r.operand_mask = '0;
			r.operand_flags = '0;
			r.field_a = '0;
			r.field_b = '0;
			r.field_c = '0;
			r.mem_mode = '0;
			r.scale_log2 = '0;
			r.target_or_disp = '0;
		end
	end

	assign res = r;
endmodule

[rtl/core/instruction_predecoder_unit.sv]
// Top level of the instruction predecoder: input register, decode, result register.
// Depends on ipd_pkg, ipd_stream_if and ipd_decode.
//
// Channel | Direction | Payload
// in_ch   | sink      | instr_addr, instr_word, second_word
// out_ch  | source    | ipd_res_t result record
//
// One transaction per cycle while the output is not stalled. An accepted input passes through
// the input register and the decode into the result register, from which it is offered.
// The input register (_s1) and the result register (_s2) each hold one item;
// a stage takes a new item whenever it is empty or its item moves on.
// A stall on the output holds the result register, and the input register too once
// it is full; no item is lost or repeated.
// Reset clears both valid flags; the payload registers are not reset.
module instruction_predecoder_unit
	import ipd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ipd_stream_if.sink   in_ch,
	ipd_stream_if.source out_ch
);
	ipd_in_t  in_s1;
	logic     vld_s1;
	ipd_res_t res_s2;
	logic     vld_s2;
	ipd_res_t dec;
	logic     adv_s2;
	logic     adv_s1;

	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	ipd_decode u_dec (
		.din (in_s1),
		.res (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_ch.valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) in_s1 <= in_ch.payload;
		if (adv_s2 && vld_s1) res_s2 <= dec;
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.payload = res_s2;
endmodule

[rtl/core/ipd_checker.sv]
// Port-level checks for the instruction predecoder, bound to the top level.
// Depends on ipd_pkg for the result type and format codes.
module ipd_checker
	import ipd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input ipd_res_t out_payload
);
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_payload.length_bytes == 4'd4 ||
		(out_payload.length_bytes == 4'd8 && out_payload.format_class == FMT_MEM)))
		else $error("bad length");

	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.valid_res |-> out_payload.target_or_disp == '0 &&
		out_payload.operand_flags == '0) else $error("invalid item carries fields");

	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.format_class != FMT_MEM |-> out_payload.mem_mode == '0)
		else $error("mode outside memory format");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled result changed");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid) else $error("accepted item lost");
endmodule

bind instruction_predecoder_unit ipd_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
